// File: rtl/heartbeat_membership_table_defines.svh
// Assertion macros shared by the heartbeat membership table RTL.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_DEFINES_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define HBMT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HBMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `HBMT_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define HBMT_ASSERT(lbl, clk, rstn, prop, msg)
`define HBMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: rtl/hbmt_pkg.sv
// Types and constants of the heartbeat membership table.
package hbmt_pkg;

  localparam int ID_W   = 32;
  localparam int PORT_W = 16;
  localparam int BEAT_W = 32;
  localparam int TMO_W  = 16;
  localparam int CFG_W  = 32;
  localparam int DATA_W = ID_W + PORT_W + BEAT_W;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd40;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_BEAT     = 2'd0;
  localparam logic [1:0] OP_SCAN     = 2'd1;
  localparam logic [1:0] OP_GOSSIP   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOCAL_ID   = 2'd0;
  localparam logic [1:0] CFG_LOCAL_PORT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_UPDATED = 3'd1,
    KIND_STALE   = 3'd2,
    KIND_SELF    = 3'd3,
    KIND_FULL    = 3'd4,
    KIND_REMOVED = 3'd5,
    KIND_NONE    = 3'd6,
    KIND_GOSSIP  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [PORT_W-1:0] port;
    logic [BEAT_W-1:0] beat;
    logic              dead;
  } row_t;

  typedef struct packed {
    logic id_match;
    logic newer;
    logic lag_out;
  } eval_t;

endpackage

// File: rtl/hbmt_eval.sv
// Shared compare unit: matches one table row against the current item and the local beat.
module hbmt_eval
  import hbmt_pkg::*;
(
  input  row_t              row_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [BEAT_W-1:0] beat_i,
  input  logic [BEAT_W-1:0] own_beat_i,
  input  logic [TMO_W-1:0]  timeout_i,
  output eval_t             eval_o
);

  logic [BEAT_W-1:0] lag;

  // The lag wraps modulo 2^32; a negative lag never times out.
  assign lag = own_beat_i - row_i.beat;

  assign eval_o.id_match = (row_i.ident == id_i);
  assign eval_o.newer    = (row_i.beat < beat_i);
  assign eval_o.lag_out  = !lag[BEAT_W-1] &&
                           (lag > {{(BEAT_W-TMO_W){1'b0}}, timeout_i});

endmodule

// File: rtl/heartbeat_membership_table.sv
// Top level of the heartbeat membership table with its sequencer and row memory.
//
//  Channel  | Handshake                        | Payload
//  ---------+----------------------------------+---------------------------------------
//  s_axis   | s_axis_tvalid_i / s_axis_tready_o | tuser: operation; tdata: id, port, beat
//  m_axis   | m_axis_tvalid_o / m_axis_tready_i | tuser: kind; tdata: id, port, beat; tlast
//  cfg      | cfg_we_i (no wait)               | cfg_idx_i, cfg_wdata_i
//
// A scan and a gossip dump walk every stored entry; a heartbeat walk stops at a match.
// The single read port of the row memory sets the pace: one row is compared per cycle
// unless the walk pauses as described below.
// Results leave through a one-deep holding register and an output register, so the walk
// pauses only when a result is found while both are occupied.
// No clearing pass is needed after reset; the entry count bounds every read.
`include "heartbeat_membership_table_defines.svh"

module heartbeat_membership_table
  import hbmt_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,   // member_id, member_port, member_beat
  input  logic [1:0]        s_axis_tuser_i,   // operation
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,   // out_id, out_port, out_beat
  output logic [2:0]        m_axis_tuser_o,   // kind
  output logic              m_axis_tlast_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPEND,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [1:0]        op_q;
  logic [ID_W-1:0]   id_q;
  logic [PORT_W-1:0] port_q;
  logic [BEAT_W-1:0] beat_q;
  logic [IW-1:0]     idx_q;
  logic [CW-1:0]     cnt_q;
  logic [BEAT_W-1:0] own_beat_q;
  logic [ID_W-1:0]   local_id_q;
  logic [PORT_W-1:0] local_port_q;
  logic [TMO_W-1:0]  timeout_q;

  logic              pend_valid_q;
  kind_e             pend_kind_q;
  logic [ID_W-1:0]   pend_id_q;
  logic [PORT_W-1:0] pend_port_q;
  logic [BEAT_W-1:0] pend_beat_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [ID_W-1:0]   out_id_q;
  logic [PORT_W-1:0] out_port_q;
  logic [BEAT_W-1:0] out_beat_q;
  logic              out_last_q;

  row_t              mem_q [ENTRIES];
  row_t              rd_row_q;

  // Input payload fields.
  logic [ID_W-1:0]   in_id;
  logic [PORT_W-1:0] in_port;
  logic [BEAT_W-1:0] in_beat;
  logic              accept;

  eval_t             ev;
  logic              out_free;
  logic              out_load;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     last_idx;
  logic              has_res;
  kind_e             res_kind;
  logic [ID_W-1:0]   res_id;
  logic [PORT_W-1:0] res_port;
  logic [BEAT_W-1:0] res_beat;
  logic              res_wr;
  row_t              res_row;
  logic              walk_end;
  logic              stall;
  logic              advance;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_addr;
  row_t              mem_row;

  assign in_id   = s_axis_tdata_i[ID_W-1:0];
  assign in_port = s_axis_tdata_i[ID_W+PORT_W-1:ID_W];
  assign in_beat = s_axis_tdata_i[DATA_W-1:ID_W+PORT_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_beat_q, out_port_q, out_id_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cnt_m1   = cnt_q - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];

  hbmt_eval u_eval (
    .row_i      (rd_row_q),
    .id_i       (id_q),
    .beat_i     (beat_q),
    .own_beat_i (own_beat_q),
    .timeout_i  (timeout_q),
    .eval_o     (ev)
  );

  // Decision for the row currently held in the read register.
  always_comb begin
    has_res  = 1'b0;
    res_kind = KIND_NONE;
    res_id   = rd_row_q.ident;
    res_port = rd_row_q.port;
    res_beat = rd_row_q.beat;
    res_wr   = 1'b0;
    res_row  = rd_row_q;
    walk_end = 1'b0;
    case (op_q)
      OP_BEAT: begin
        walk_end = ev.id_match || (idx_q == last_idx);
        if (ev.id_match) begin
          has_res = 1'b1;
          if (ev.newer) begin
            res_kind     = KIND_UPDATED;
            res_beat     = beat_q;
            res_wr       = 1'b1;
            res_row.beat = beat_q;
          end else begin
            res_kind = KIND_STALE;
          end
        end
      end
      OP_SCAN: begin
        walk_end = (idx_q == last_idx);
        if (!rd_row_q.dead && ev.lag_out) begin
          has_res      = 1'b1;
          res_kind     = KIND_REMOVED;
          res_wr       = 1'b1;
          res_row.dead = 1'b1;
        end
      end
      OP_GOSSIP: begin
        walk_end = (idx_q == '0);
        if (!rd_row_q.dead) begin
          has_res  = 1'b1;
          res_kind = KIND_GOSSIP;
        end
      end
      default: begin
        walk_end = 1'b1;
      end
    endcase
  end

  assign stall   = has_res && pend_valid_q && !out_free;
  assign advance = (state_q == ST_WALK) && !stall;

  // The output register takes a new item in this cycle.
  assign out_load = (advance && has_res && pend_valid_q) || (state_q == ST_FIN && out_free);

  // Row memory access: one read and one write per cycle.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    mem_addr = idx_q;
    mem_row  = res_row;
    if (accept && cnt_q != '0) begin
      case (s_axis_tuser_i)
        OP_BEAT: begin
          rd_en = (in_id != local_id_q);
        end
        OP_SCAN: begin
          rd_en = 1'b1;
        end
        OP_GOSSIP: begin
          rd_en   = 1'b1;
          rd_addr = last_idx;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end
    if (advance && !walk_end) begin
      rd_en   = 1'b1;
      rd_addr = (op_q == OP_GOSSIP) ? idx_q - IW'(1) : idx_q + IW'(1);
    end
    if (advance && res_wr) begin
      mem_we = 1'b1;
    end
    if (state_q == ST_APPEND && cnt_q < CW'(ENTRIES)) begin
      mem_we   = 1'b1;
      mem_addr = cnt_q[IW-1:0];
      mem_row  = '{ident: id_q, port: port_q, beat: beat_q, dead: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_row;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_BEAT;
      id_q         <= '0;
      port_q       <= '0;
      beat_q       <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      own_beat_q   <= '0;
      local_id_q   <= '0;
      local_port_q <= '0;
      timeout_q    <= TIMEOUT_RESET;
      pend_valid_q <= 1'b0;
      pend_kind_q  <= KIND_NONE;
      pend_id_q    <= '0;
      pend_port_q  <= '0;
      pend_beat_q  <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_NONE;
      out_id_q     <= '0;
      out_port_q   <= '0;
      out_beat_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOCAL_ID:   local_id_q   <= cfg_wdata_i[ID_W-1:0];
          CFG_LOCAL_PORT: local_port_q <= cfg_wdata_i[PORT_W-1:0];
          CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i[TMO_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q   <= s_axis_tuser_i;
            id_q   <= in_id;
            port_q <= in_port;
            beat_q <= in_beat;
            idx_q  <= (s_axis_tuser_i == OP_GOSSIP) ? last_idx : '0;
            case (s_axis_tuser_i)
              OP_BEAT: begin
                if (in_id == local_id_q) begin
                  pend_valid_q <= 1'b1;
                  pend_kind_q  <= KIND_SELF;
                  pend_id_q    <= in_id;
                  pend_port_q  <= in_port;
                  pend_beat_q  <= in_beat;
                  state_q      <= ST_FIN;
                end else if (cnt_q == '0) begin
                  state_q <= ST_APPEND;
                end else begin
                  state_q <= ST_WALK;
                end
              end
              OP_SCAN: begin
                state_q <= (cnt_q == '0) ? ST_FIN : ST_WALK;
              end
              OP_GOSSIP: begin
                // The local record goes first; the walk then runs newest first.
                pend_valid_q <= 1'b1;
                pend_kind_q  <= KIND_GOSSIP;
                pend_id_q    <= local_id_q;
                pend_port_q  <= local_port_q;
                pend_beat_q  <= own_beat_q;
                own_beat_q   <= own_beat_q + BEAT_W'(1);
                state_q      <= (cnt_q == '0) ? ST_FIN : ST_WALK;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end

        ST_WALK: begin
          if (advance) begin
            // A result is held back one step so that the final one can carry tlast.
            if (has_res) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= pend_kind_q;
                out_id_q    <= pend_id_q;
                out_port_q  <= pend_port_q;
                out_beat_q  <= pend_beat_q;
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_kind_q  <= res_kind;
              pend_id_q    <= res_id;
              pend_port_q  <= res_port;
              pend_beat_q  <= res_beat;
            end
            if (walk_end) begin
              state_q <= (op_q == OP_BEAT && !ev.id_match) ? ST_APPEND : ST_FIN;
            end else begin
              idx_q <= rd_addr;
            end
          end
        end

        ST_APPEND: begin
          pend_valid_q <= 1'b1;
          pend_id_q    <= id_q;
          pend_port_q  <= port_q;
          pend_beat_q  <= beat_q;
          if (cnt_q < CW'(ENTRIES)) begin
            pend_kind_q <= KIND_ADDED;
            cnt_q       <= cnt_q + CW'(1);
          end else begin
            pend_kind_q <= KIND_FULL;
          end
          state_q <= ST_FIN;
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
            if (pend_valid_q) begin
              out_kind_q <= pend_kind_q;
              out_id_q   <= pend_id_q;
              out_port_q <= pend_port_q;
              out_beat_q <= pend_beat_q;
            end else begin
              out_kind_q <= KIND_NONE;
              out_id_q   <= '0;
              out_port_q <= '0;
              out_beat_q <= '0;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `HBMT_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CW'(ENTRIES), "entry count overflow")
  `HBMT_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_valid_q, "pending result left in idle")
  `HBMT_ASSERT(a_beat_inc, clk_i, rst_ni, (accept && s_axis_tuser_i == OP_GOSSIP) |=> (own_beat_q == $past(own_beat_q) + 32'd1), "local beat not advanced")
  `HBMT_ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, mem_we && state_q == ST_IDLE, "table written while idle")

endmodule
